>>> sv/battery_gauge_led_indicator_top_defines.svh
// Assertion macros for the battery gauge top level
`ifndef BATTERY_GAUGE_LED_INDICATOR_TOP_DEFINES_SVH
`define BATTERY_GAUGE_LED_INDICATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define BGLI_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define BGLI_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bgli_pkg.sv
// Shared widths, constants, register codes and types of the battery gauge
`default_nettype none
package bgli_pkg;

   localparam int RAW_W     = 12;
   localparam int MV_W      = 13;
   localparam int PCT_W     = 7;
   localparam int CS_W      = 2;
   localparam int SUM_W     = 18;
   localparam int FILT_W    = 20;
   localparam int FCNT_W    = 6;
   localparam int AVG_W     = 26;
   localparam int PROD_W    = 24;
   localparam int CONV_W    = 12;
   localparam int DIV_W     = 27;
   localparam int DVSR_W    = 13;
   localparam int STEP_W    = 5;
   localparam int LFSR_W    = 8;

   localparam int PADDR_W   = 5;
   localparam int PDATA_W   = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [PROD_W-1:0] ADC_SCALE   = PROD_W'(3300);
   localparam logic [PROD_W+1:0] ADC_FULL    = (PROD_W+2)'(4095);
   localparam logic [DIV_W-1:0]  FILT_WEIGHT = DIV_W'(9);
   localparam logic [DVSR_W-1:0] FILT_DIV    = DVSR_W'(10);
   localparam logic [DIV_W-1:0]  PCT_SCALE   = DIV_W'(100);
   localparam logic [PCT_W-1:0]  PCT_MAX     = PCT_W'(100);
   localparam logic [FCNT_W-1:0] FCNT_MAX    = FCNT_W'(63);

   localparam logic [CS_W-1:0] CHG_NONE   = 2'd0;
   localparam logic [CS_W-1:0] CHG_ACTIVE = 2'd1;
   localparam logic [CS_W-1:0] CHG_DONE   = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_MONITOR_ENABLE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_FORCED_MV      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_EMPTY_MV       = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FULL_MV        = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LOW_PERCENT    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_FULL_CONFIRM   = 3'd5;

   localparam logic              RST_MONITOR_ENABLE = 1'b1;
   localparam logic [MV_W-1:0]   RST_FORCED_MV      = MV_W'(0);
   localparam logic [MV_W-1:0]   RST_EMPTY_MV       = MV_W'(3400);
   localparam logic [MV_W-1:0]   RST_FULL_MV        = MV_W'(4100);
   localparam logic [PCT_W-1:0]  RST_LOW_PERCENT    = PCT_W'(2);
   localparam logic [FCNT_W-1:0] RST_FULL_CONFIRM   = FCNT_W'(32);

   typedef struct packed {
      logic              monitor_enable;
      logic [MV_W-1:0]   forced_mv;
      logic [MV_W-1:0]   empty_mv;
      logic [MV_W-1:0]   full_mv;
      logic [PCT_W-1:0]  low_percent;
      logic [FCNT_W-1:0] full_confirm;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

>>> sv/bgli_channels.sv
// Request and response channel interfaces of the battery gauge
`default_nettype none
interface bgli_req_if;
   logic                         valid;
   logic                         ready;
   logic [bgli_pkg::RAW_W-1:0]   adc_raw;
   logic                         usb_present;
   logic                         charge_pin;

   modport source (output valid, adc_raw, usb_present, charge_pin, input ready);
   modport sink   (input valid, adc_raw, usb_present, charge_pin, output ready);
endinterface

interface bgli_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bgli_pkg::MV_W-1:0]    battery_mv;
   logic [bgli_pkg::PCT_W-1:0]   percent;
   logic [bgli_pkg::CS_W-1:0]    charge_state;
   logic                         led_on;

   modport source (output valid, battery_mv, percent, charge_state, led_on, input ready);
   modport sink   (input valid, battery_mv, percent, charge_state, led_on, output ready);
endinterface
`default_nettype wire

>>> sv/battery_gauge_led_indicator_top.sv
// Battery gauge top level: sample conversion, window sequencer, filter, percent and LED.
// A sample that does not close a window passes through S_EST and S_ACC to ready again.
// A window-closing sample makes up to three passes through the 27-step shared divider
// (average, filter, percent), skipping the filter pass when the empty filter loads and the
// percent pass when no divide is needed; the LED step stalls until the output is free.
// Synchronous active-high reset clears window, filter, LED and response state; registers take defaults.
`default_nettype none
`include "battery_gauge_led_indicator_top_defines.svh"
module battery_gauge_led_indicator_top #(
   parameter int SAMPLES = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bgli_req_if.sink                            req_ch,
   bgli_rsp_if.source                          rsp_ch,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [bgli_pkg::PADDR_W-1:0]   paddr,
   input  wire logic [bgli_pkg::PDATA_W-1:0]   pwdata,
   output logic      [bgli_pkg::PDATA_W-1:0]   prdata,
   output logic                                pready
);

   localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);
   localparam logic [bgli_pkg::DVSR_W-1:0] SAMPLES_DVSR = bgli_pkg::DVSR_W'(SAMPLES);

   typedef enum logic [3:0] {
      S_IDLE, S_EST, S_ACC, S_AVG_W, S_FLT, S_FLT_W, S_MV, S_PCT, S_PCT_W, S_LED
   } state_type;

   bgli_pkg::cfg_type       cfg;
   bgli_pkg::div_req_type   div_req;
   bgli_pkg::div_rsp_type   div_rsp;

   state_type                        state_ff;
   logic [bgli_pkg::PROD_W-1:0]      prod_ff;
   logic [bgli_pkg::CONV_W-1:0]      q0_ff;
   logic                             usb_ff;
   logic                             chg_ff;
   logic [bgli_pkg::SUM_W-1:0]       sum_ff;
   logic [IDX_W-1:0]                 idx_ff;
   logic [bgli_pkg::AVG_W-1:0]       avg_ff;
   logic [bgli_pkg::FILT_W-1:0]      filt_ff;
   logic [bgli_pkg::MV_W-1:0]        mv_ff;
   logic [bgli_pkg::PCT_W-1:0]       pct_ff;
   logic                             led_ff;
   logic [bgli_pkg::FCNT_W-1:0]      fcnt_ff;
   logic                             latched_ff;
   logic                             rsp_valid_ff;
   logic [bgli_pkg::MV_W-1:0]        rsp_mv_ff;
   logic [bgli_pkg::PCT_W-1:0]       rsp_pct_ff;
   logic [bgli_pkg::CS_W-1:0]        rsp_cs_ff;
   logic                             rsp_led_ff;

   logic [bgli_pkg::PROD_W-1:0]      prod_in;
   logic [bgli_pkg::PROD_W:0]        est_sum;
   logic [bgli_pkg::CONV_W-1:0]      q0_in;
   logic signed [bgli_pkg::PROD_W+1:0] conv_rem;
   logic [bgli_pkg::CONV_W-1:0]      conv_val;
   logic [bgli_pkg::SUM_W-1:0]       sum_in;
   logic                             window_end;
   logic [bgli_pkg::MV_W-1:0]        mv_in;
   logic                             span_ok;
   logic                             above_empty;
   logic [bgli_pkg::MV_W-1:0]        span;
   logic [bgli_pkg::MV_W-1:0]        mv_over;
   logic [bgli_pkg::CS_W-1:0]        cstate;
   logic                             led_in;
   logic [bgli_pkg::FCNT_W-1:0]      fcnt_in;
   logic                             latched_in;
   logic [bgli_pkg::FCNT_W-1:0]      fcnt_inc;
   logic                             out_free;
   logic                             rsp_load;

   bgli_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bgli_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // raw * 3300 / 4095: estimate via the 2^12-1 identity, then correct by one
   assign prod_in  = bgli_pkg::PROD_W'(req_ch.adc_raw) * bgli_pkg::ADC_SCALE;
   assign est_sum  = {1'b0, prod_ff} + ({1'b0, prod_ff} >> bgli_pkg::RAW_W) + 1'b1;
   assign q0_in    = bgli_pkg::CONV_W'(est_sum >> bgli_pkg::RAW_W);
   assign conv_rem = $signed({2'b00, prod_ff})
                   - $signed({2'b00, q0_ff, {bgli_pkg::RAW_W{1'b0}}})
                   + $signed({{(bgli_pkg::PROD_W+2-bgli_pkg::CONV_W){1'b0}}, q0_ff});

   always_comb begin
      priority if (conv_rem < 0) begin
         conv_val = q0_ff - 1'b1;
      end else if (conv_rem >= $signed(bgli_pkg::ADC_FULL)) begin
         conv_val = q0_ff + 1'b1;
      end else begin
         conv_val = q0_ff;
      end
   end

   assign sum_in     = sum_ff + bgli_pkg::SUM_W'(conv_val);
   assign window_end = (idx_ff == IDX_LAST);

   assign mv_in = (cfg.forced_mv != '0) ? cfg.forced_mv
                : filt_ff[bgli_pkg::FILT_W-1:bgli_pkg::FILT_W-bgli_pkg::MV_W];
   assign span_ok     = cfg.full_mv > cfg.empty_mv;
   assign above_empty = mv_ff > cfg.empty_mv;
   assign span        = cfg.full_mv - cfg.empty_mv;
   assign mv_over     = mv_ff - cfg.empty_mv;

   assign cstate = !usb_ff ? bgli_pkg::CHG_NONE
                 : (!chg_ff ? bgli_pkg::CHG_ACTIVE : bgli_pkg::CHG_DONE);

   assign fcnt_inc = (fcnt_ff < bgli_pkg::FCNT_MAX) ? fcnt_ff + 1'b1 : fcnt_ff;

   always_comb begin
      led_in     = led_ff;
      fcnt_in    = fcnt_ff;
      latched_in = latched_ff;
      if (cfg.monitor_enable) begin
         priority if (pct_ff < cfg.low_percent) begin
            led_in = ~led_ff;
         end else if (cstate == bgli_pkg::CHG_DONE || latched_ff) begin
            fcnt_in = fcnt_inc;
            led_in  = 1'b0;
            if (fcnt_inc >= cfg.full_confirm) begin
               latched_in = 1'b1;
            end
         end else if (cstate == bgli_pkg::CHG_ACTIVE) begin
            fcnt_in    = '0;
            latched_in = 1'b0;
            led_in     = 1'b1;
         end else begin
            led_in = 1'b0;
         end
      end
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = SAMPLES_DVSR;
      unique case (state_ff)
         S_ACC: begin
            div_req.start    = window_end;
            div_req.dividend = bgli_pkg::DIV_W'({sum_in, 8'd0});
            div_req.divisor  = SAMPLES_DVSR;
         end
         S_FLT: begin
            div_req.start    = 1'b1;
            div_req.dividend = bgli_pkg::DIV_W'(filt_ff) * bgli_pkg::FILT_WEIGHT
                             + bgli_pkg::DIV_W'(avg_ff);
            div_req.divisor  = bgli_pkg::FILT_DIV;
         end
         S_PCT: begin
            div_req.start    = span_ok & above_empty;
            div_req.dividend = bgli_pkg::DIV_W'(mv_over) * bgli_pkg::PCT_SCALE;
            div_req.divisor  = span;
         end
         default: ;
      endcase
   end

   assign out_free = ~rsp_valid_ff | rsp_ch.ready;
   assign rsp_load = (state_ff == S_LED) & out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         idx_ff       <= '0;
         filt_ff      <= '0;
         led_ff       <= 1'b0;
         fcnt_ff      <= '0;
         latched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  prod_ff  <= prod_in;
                  usb_ff   <= req_ch.usb_present;
                  chg_ff   <= req_ch.charge_pin;
                  state_ff <= S_EST;
               end
            end
            S_EST: begin
               q0_ff    <= q0_in;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (window_end) begin
                  sum_ff   <= '0;
                  idx_ff   <= '0;
                  state_ff <= S_AVG_W;
               end else begin
                  sum_ff   <= sum_in;
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_AVG_W: begin
               if (div_rsp.done) begin
                  avg_ff <= div_rsp.quotient[bgli_pkg::AVG_W-1:0];
                  // empty filter loads the window average directly
                  if (filt_ff == '0) begin
                     filt_ff  <= div_rsp.quotient[bgli_pkg::FILT_W-1:0];
                     state_ff <= S_MV;
                  end else begin
                     state_ff <= S_FLT;
                  end
               end
            end
            S_FLT: begin
               state_ff <= S_FLT_W;
            end
            S_FLT_W: begin
               if (div_rsp.done) begin
                  filt_ff  <= div_rsp.quotient[bgli_pkg::FILT_W-1:0];
                  state_ff <= S_MV;
               end
            end
            S_MV: begin
               mv_ff    <= mv_in;
               state_ff <= S_PCT;
            end
            S_PCT: begin
               priority if (!span_ok) begin
                  pct_ff   <= (mv_ff >= cfg.full_mv) ? bgli_pkg::PCT_MAX : '0;
                  state_ff <= S_LED;
               end else if (!above_empty) begin
                  pct_ff   <= '0;
                  state_ff <= S_LED;
               end else begin
                  state_ff <= S_PCT_W;
               end
            end
            S_PCT_W: begin
               if (div_rsp.done) begin
                  pct_ff <= (div_rsp.quotient > bgli_pkg::DIV_W'(bgli_pkg::PCT_MAX))
                          ? bgli_pkg::PCT_MAX
                          : div_rsp.quotient[bgli_pkg::PCT_W-1:0];
                  state_ff <= S_LED;
               end
            end
            S_LED: begin
               // hold until the output register is free
               if (out_free) begin
                  led_ff       <= led_in;
                  fcnt_ff      <= fcnt_in;
                  latched_ff   <= latched_in;
                  rsp_mv_ff    <= mv_ff;
                  rsp_pct_ff   <= pct_ff;
                  rsp_cs_ff    <= cstate;
                  rsp_led_ff   <= led_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.battery_mv   = rsp_mv_ff;
   assign rsp_ch.percent      = rsp_pct_ff;
   assign rsp_ch.charge_state = rsp_cs_ff;
   assign rsp_ch.led_on       = rsp_led_ff;

   `BGLI_ASSERT_IMP(a_idle_div_free, req_ch.ready, !div_rsp.busy, "request taken while divider busy")
   `BGLI_ASSERT_NXT(a_window_starts_div, (state_ff == S_ACC) && window_end, div_rsp.busy, "window close did not start divider")
   `BGLI_ASSERT_IMP(a_idx_range, 1'b1, idx_ff <= IDX_LAST, "sample index past window")
   `BGLI_ASSERT_IMP(a_rsp_from_led, $rose(rsp_valid_ff), $past(state_ff) == S_LED, "response raised outside LED step")

endmodule
`default_nettype wire

>>> sv/bgli_csr.sv
// APB-style configuration registers of the battery gauge
`default_nettype none
module bgli_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [bgli_pkg::PADDR_W-1:0]   paddr,
   input  wire logic [bgli_pkg::PDATA_W-1:0]   pwdata,
   output logic      [bgli_pkg::PDATA_W-1:0]   prdata,
   output logic                                pready,
   output bgli_pkg::cfg_type                   cfg
);

   logic                             monitor_enable_ff;
   logic [bgli_pkg::MV_W-1:0]        forced_mv_ff;
   logic [bgli_pkg::MV_W-1:0]        empty_mv_ff;
   logic [bgli_pkg::MV_W-1:0]        full_mv_ff;
   logic [bgli_pkg::PCT_W-1:0]       low_percent_ff;
   logic [bgli_pkg::FCNT_W-1:0]      full_confirm_ff;
   logic [bgli_pkg::REG_IDX_W-1:0]   reg_idx;
   logic                             wr_en;

   assign reg_idx = paddr[bgli_pkg::PADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         monitor_enable_ff <= bgli_pkg::RST_MONITOR_ENABLE;
         forced_mv_ff      <= bgli_pkg::RST_FORCED_MV;
         empty_mv_ff       <= bgli_pkg::RST_EMPTY_MV;
         full_mv_ff        <= bgli_pkg::RST_FULL_MV;
         low_percent_ff    <= bgli_pkg::RST_LOW_PERCENT;
         full_confirm_ff   <= bgli_pkg::RST_FULL_CONFIRM;
      end else if (wr_en) begin
         unique case (reg_idx)
            bgli_pkg::REG_MONITOR_ENABLE: monitor_enable_ff <= pwdata[0];
            bgli_pkg::REG_FORCED_MV:      forced_mv_ff <= pwdata[bgli_pkg::MV_W-1:0];
            bgli_pkg::REG_EMPTY_MV:       empty_mv_ff <= pwdata[bgli_pkg::MV_W-1:0];
            bgli_pkg::REG_FULL_MV:        full_mv_ff <= pwdata[bgli_pkg::MV_W-1:0];
            bgli_pkg::REG_LOW_PERCENT:    low_percent_ff <= pwdata[bgli_pkg::PCT_W-1:0];
            bgli_pkg::REG_FULL_CONFIRM:   full_confirm_ff <= pwdata[bgli_pkg::FCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         bgli_pkg::REG_MONITOR_ENABLE: prdata = bgli_pkg::PDATA_W'(monitor_enable_ff);
         bgli_pkg::REG_FORCED_MV:      prdata = bgli_pkg::PDATA_W'(forced_mv_ff);
         bgli_pkg::REG_EMPTY_MV:       prdata = bgli_pkg::PDATA_W'(empty_mv_ff);
         bgli_pkg::REG_FULL_MV:        prdata = bgli_pkg::PDATA_W'(full_mv_ff);
         bgli_pkg::REG_LOW_PERCENT:    prdata = bgli_pkg::PDATA_W'(low_percent_ff);
         bgli_pkg::REG_FULL_CONFIRM:   prdata = bgli_pkg::PDATA_W'(full_confirm_ff);
         default:                      prdata = '0;
      endcase
   end

   assign cfg.monitor_enable = monitor_enable_ff;
   assign cfg.forced_mv      = forced_mv_ff;
   assign cfg.empty_mv       = empty_mv_ff;
   assign cfg.full_mv        = full_mv_ff;
   assign cfg.low_percent    = low_percent_ff;
   assign cfg.full_confirm   = full_confirm_ff;

endmodule
`default_nettype wire

>>> sv/bgli_div.sv
// Shared restoring divider, one quotient bit per cycle
`default_nettype none
module bgli_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  bgli_pkg::div_req_type      div_req,
   output bgli_pkg::div_rsp_type      div_rsp
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [bgli_pkg::STEP_W-1:0]       step_ff;
   logic [bgli_pkg::DIV_W-1:0]        quo_ff;
   logic [bgli_pkg::DVSR_W-1:0]       rem_ff;
   logic [bgli_pkg::DVSR_W-1:0]       dvsr_ff;
   logic [bgli_pkg::DVSR_W:0]         rem_shift;
   logic [bgli_pkg::DVSR_W+1:0]       diff;
   logic                              fits;
   logic                              load;

   assign load      = div_req.start & ~busy_ff;
   assign rem_shift = {rem_ff, quo_ff[bgli_pkg::DIV_W-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, dvsr_ff};
   assign fits      = ~diff[bgli_pkg::DVSR_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == bgli_pkg::STEP_W'(bgli_pkg::DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift in one dividend bit, subtract when the divisor fits
   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff  <= div_req.dividend;
         rem_ff  <= '0;
         dvsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[bgli_pkg::DVSR_W-1:0] : rem_shift[bgli_pkg::DVSR_W-1:0];
         quo_ff <= {quo_ff[bgli_pkg::DIV_W-2:0], fits};
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire
